>>> sv/fastq_kmer_extractor_unit_defines.svh
// Assertion macros shared by the FASTQ k-mer extractor RTL.
// Used by files that check their own logic; depends on nothing.
`ifndef FASTQ_KMER_EXTRACTOR_UNIT_DEFINES_SVH
`define FASTQ_KMER_EXTRACTOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on aclk and silenced during reset.
`define FKX_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk and silenced during reset.
`define FKX_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/fkx_pkg.sv
// Package of the FASTQ k-mer extractor: widths, codes and shared types.
// Used by fkx_window and fastq_kmer_extractor_unit; depends on nothing.
`timescale 1ns / 1ps

package fkx_pkg;

    localparam int MAX_K     = 32;
    localparam int MIN_K     = 2;
    localparam int RESET_K   = 16;
    localparam int CFG_W     = 6;
    localparam int FILL_W    = $clog2(MAX_K + 1);
    localparam int KMER_BITS = MAX_K * 8;
    localparam int POS_W     = 48;
    localparam int IDX_W     = 32;
    localparam int OUT_BITS  = KMER_BITS + 1 + IDX_W + POS_W + POS_W + IDX_W + POS_W;
    localparam int TDATA_W   = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [7:0] CH_AT      = 8'h40;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_EOF  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        KIND_KMER   = 2'd0,
        KIND_RECORD = 2'd1,
        KIND_EOF    = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_SEQ    = 2'd1,
        PH_QUAL   = 2'd2
    } phase_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } win_ctrl_t;

endpackage

>>> sv/fkx_window.sv
// K-mer window: a byte shift register with fill count and k-mer alignment.
// Depends on fkx_pkg.
`timescale 1ns / 1ps

module fkx_window (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  fkx_pkg::win_ctrl_t            ctrl,
    input  logic [7:0]                    base_byte,
    input  logic [fkx_pkg::FILL_W-1:0]    eff_k,
    output logic [fkx_pkg::KMER_BITS-1:0] kmer,
    output logic                          kmer_hit
);
    import fkx_pkg::*;

    logic [KMER_BITS-1:0] win_reg;
    logic [KMER_BITS-1:0] win_shift;
    logic [FILL_W-1:0]    fill_reg;
    logic [FILL_W-1:0]    fill_next;
    logic [FILL_W-1:0]    fill_inc;
    logic [FILL_W-1:0]    drop;
    logic [FILL_W+2:0]    shamt;

    // The newest byte enters at the top; the oldest of the last k bytes
    // lands in byte 0 after the right shift.
    assign win_shift = {base_byte, win_reg[KMER_BITS-1:8]};
    assign fill_inc  = (fill_reg < FILL_W'(MAX_K)) ? fill_reg + 1'b1 : fill_reg;
    assign kmer_hit  = (fill_inc >= eff_k);
    assign drop      = FILL_W'(MAX_K) - eff_k;
    assign shamt     = {drop, 3'b000};
    assign kmer      = win_shift >> shamt;

    always_comb begin
        fill_next = fill_reg;
        priority if (ctrl.clear) begin
            fill_next = '0;
        end else if (ctrl.shift) begin
            fill_next = fill_inc;
        end else begin
            fill_next = fill_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            win_reg <= win_shift;
        end
    end

endmodule

>>> sv/fastq_kmer_extractor_unit.sv
// Latency: a beat accepted into the input register is parsed there and its result is held in the result register.
// Throughput: one beat per cycle; the input register and the result register form a
// two-stage pipeline whose stall comes only from m_tready.
// Reset (aresetn low, synchronous): clears phase, counters, offsets and fill, and sets
// kmer_length to 16. End of file returns all per-file state to these values.
`timescale 1ns / 1ps

module fastq_kmer_extractor_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [fkx_pkg::CFG_W-1:0]   cfg_wdata,   // kmer_length
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,     // byte_value
    input  logic [0:0]                  s_tuser,     // op
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // m_tdata from bit 0: kmer_word0, kmer_word1, kmer_word2, kmer_word3, record_valid,
    // record_id, record_start, record_end, read_count, base_count, zero pad
    output logic [fkx_pkg::TDATA_W-1:0] m_tdata,
    output logic [1:0]                  m_tuser      // kind
);
    import fkx_pkg::*;
    `include "fastq_kmer_extractor_unit_defines.svh"

    // Configuration, stored already clamped.
    logic [FILL_W-1:0] eff_k_reg;

    // Input stage.
    logic       in_valid_reg;
    op_t        in_op_reg;
    logic [7:0] in_byte_reg;

    // Per-file state.
    phase_t             phase_reg, phase_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [POS_W-1:0]   start_reg, start_next;
    logic [POS_W-1:0]   last_reg, last_next;
    logic               open_reg, open_next;
    logic [IDX_W-1:0]   index_reg, index_next;
    logic [POS_W-1:0]   bases_reg, bases_next;

    // Result stage.
    logic               m_valid_reg, m_valid_next;
    kind_t              m_kind_reg, m_kind_next;
    logic [KMER_BITS-1:0] m_kmer_reg, m_kmer_next;
    logic               m_rv_reg, m_rv_next;
    logic [IDX_W-1:0]   m_id_reg, m_id_next;
    logic [POS_W-1:0]   m_start_reg, m_start_next;
    logic [POS_W-1:0]   m_end_reg, m_end_next;
    logic [IDX_W-1:0]   m_rc_reg, m_rc_next;
    logic [POS_W-1:0]   m_bc_reg, m_bc_next;

    logic advance, proc;
    logic is_eof, is_at, is_plus, is_nl, is_base;
    logic [POS_W-1:0] pos_inc, bases_inc;
    logic [IDX_W-1:0] index_inc;
    win_ctrl_t win_ctrl;
    logic [KMER_BITS-1:0] win_kmer;
    logic win_hit;

    assign advance  = !m_valid_reg || m_tready;
    assign proc     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    assign is_eof  = (in_op_reg == OP_EOF);
    assign is_at   = !is_eof && (in_byte_reg == CH_AT);
    assign is_plus = !is_eof && (in_byte_reg == CH_PLUS);
    assign is_nl   = !is_eof && (in_byte_reg == CH_NEWLINE);
    assign is_base = !is_eof && !is_at && !is_plus && !is_nl && (phase_reg == PH_SEQ);

    assign pos_inc   = (&pos_reg)   ? pos_reg   : pos_reg + 1'b1;
    assign bases_inc = (&bases_reg) ? bases_reg : bases_reg + 1'b1;
    assign index_inc = (&index_reg) ? index_reg : index_reg + 1'b1;

    assign win_ctrl.shift = proc && is_base;
    assign win_ctrl.clear = proc && (is_eof || is_at);

    fkx_window u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (win_ctrl),
        .base_byte (in_byte_reg),
        .eff_k     (eff_k_reg),
        .kmer      (win_kmer),
        .kmer_hit  (win_hit)
    );

    // Phase next state.
    always_comb begin
        phase_next = phase_reg;
        if (proc) begin
            priority if (is_eof || is_at) begin
                phase_next = PH_HEADER;
            end else if (is_plus) begin
                phase_next = PH_QUAL;
            end else if (is_nl && (phase_reg == PH_HEADER)) begin
                phase_next = PH_SEQ;
            end else begin
                phase_next = phase_reg;
            end
        end
    end

    // Counters, offsets and the result of the beat in the input stage.
    always_comb begin
        pos_next     = pos_reg;
        start_next   = start_reg;
        last_next    = last_reg;
        open_next    = open_reg;
        index_next   = index_reg;
        bases_next   = bases_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_kind_next  = KIND_KMER;
        m_kmer_next  = '0;
        m_rv_next    = 1'b0;
        m_id_next    = '0;
        m_start_next = '0;
        m_end_next   = '0;
        m_rc_next    = '0;
        m_bc_next    = '0;
        if (proc) begin
            m_valid_next = 1'b0;
            pos_next     = pos_inc;
            priority if (is_eof) begin
                m_valid_next = 1'b1;
                m_kind_next  = KIND_EOF;
                m_bc_next    = bases_reg;
                if (open_reg) begin
                    m_rv_next    = 1'b1;
                    m_id_next    = index_reg;
                    m_start_next = start_reg;
                    m_end_next   = last_reg;
                    m_rc_next    = index_inc;
                end
                pos_next   = '0;
                start_next = '0;
                last_next  = '0;
                open_next  = 1'b0;
                index_next = '0;
                bases_next = '0;
            end else if (is_at) begin
                if (open_reg) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = KIND_RECORD;
                    m_rv_next    = 1'b1;
                    m_id_next    = index_reg;
                    m_start_next = start_reg;
                    m_end_next   = last_reg;
                    index_next   = index_inc;
                end else begin
                    open_next = 1'b1;
                end
            end else if (is_nl) begin
                if (phase_reg == PH_HEADER) begin
                    start_next = pos_inc;
                end
            end else if (is_base) begin
                m_valid_next = win_hit;
                m_kmer_next  = win_kmer;
                bases_next   = bases_inc;
                last_next    = pos_reg;
            end else begin
                // Plain bytes outside the sequence phase only move the position.
                m_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eff_k_reg    <= FILL_W'(RESET_K);
            in_valid_reg <= 1'b0;
            phase_reg    <= PH_HEADER;
            pos_reg      <= '0;
            start_reg    <= '0;
            last_reg     <= '0;
            open_reg     <= 1'b0;
            index_reg    <= '0;
            bases_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                priority if (cfg_wdata < CFG_W'(MIN_K)) begin
                    eff_k_reg <= FILL_W'(MIN_K);
                end else if (cfg_wdata > CFG_W'(MAX_K)) begin
                    eff_k_reg <= FILL_W'(MAX_K);
                end else begin
                    eff_k_reg <= FILL_W'(cfg_wdata);
                end
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            start_reg   <= start_next;
            last_reg    <= last_next;
            open_reg    <= open_next;
            index_reg   <= index_next;
            bases_reg   <= bases_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg   <= op_t'(s_tuser[0]);
            in_byte_reg <= s_tdata;
        end
        if (proc) begin
            m_kind_reg  <= m_kind_next;
            m_kmer_reg  <= m_kmer_next;
            m_rv_reg    <= m_rv_next;
            m_id_reg    <= m_id_next;
            m_start_reg <= m_start_next;
            m_end_reg   <= m_end_next;
            m_rc_reg    <= m_rc_next;
            m_bc_reg    <= m_bc_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = {{(TDATA_W - OUT_BITS){1'b0}}, m_bc_reg, m_rc_reg, m_end_reg,
                       m_start_reg, m_id_reg, m_rv_reg, m_kmer_reg};

    `FKX_ASSERT_IMP(a_eff_k_range,
        1'b1,
        (eff_k_reg >= FILL_W'(MIN_K)) && (eff_k_reg <= FILL_W'(MAX_K)),
        "effective k-mer length left its range")
    `FKX_ASSERT_IMP(a_kmer_no_record,
        m_tvalid && (m_tuser == KIND_KMER),
        !m_rv_reg && (m_rc_reg == '0) && (m_bc_reg == '0),
        "k-mer beat carries record or summary fields")
    `FKX_ASSERT_IMP(a_record_valid,
        m_tvalid && (m_tuser == KIND_RECORD),
        m_rv_reg && (m_kmer_reg == '0),
        "closed record beat without a valid record")
    `FKX_ASSERT_NXT(a_input_hold,
        in_valid_reg && !advance,
        in_valid_reg && $stable(in_byte_reg) && $stable(in_op_reg),
        "stalled input stage lost its item")
    `FKX_ASSERT_NXT(a_eof_clears,
        proc && is_eof,
        !open_reg && (pos_reg == '0) && (bases_reg == '0) && (phase_reg == PH_HEADER),
        "end of file did not clear per-file state")

endmodule
